// File: hdl/parallel_job_scheduler_unit_macros.svh
// ----------------------------------------------------------------------------
// parallel job scheduler assertion macros
// shared property forms for the scheduler checks
// ----------------------------------------------------------------------------
`ifndef PARALLEL_JOB_SCHEDULER_UNIT_MACROS_SVH
`define PARALLEL_JOB_SCHEDULER_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define PJS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define PJS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/pjs_pkg.sv
// ----------------------------------------------------------------------------
// pjs_pkg
// widths and constants shared by the scheduler and its channels
// ----------------------------------------------------------------------------
`default_nettype none

package pjs_pkg;

  localparam int NUM_WORKERS_DEF = 16;
  localparam int DUR_W           = 32;
  localparam int TIME_W          = 48;
  localparam int WIDX_W          = 4;
  localparam int CFG_W           = 5;

  localparam logic [CFG_W-1:0]  ACTIVE_RESET = 5'd16;
  localparam logic [TIME_W-1:0] TIME_MAX     = {TIME_W{1'b1}};

endpackage

`default_nettype wire

// File: hdl/pjs_if.sv
// ----------------------------------------------------------------------------
// pjs channel interfaces
// valid/ready channels for configuration, jobs and assignment results
// ----------------------------------------------------------------------------
`default_nettype none

interface pjs_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [pjs_pkg::CFG_W-1:0]  active_workers;

  modport source (output valid, output active_workers, input ready);
  modport sink   (input valid, input active_workers, output ready);
endinterface

interface pjs_job_if;
  logic                       valid;
  logic                       ready;
  logic [pjs_pkg::DUR_W-1:0]  job_duration;

  modport source (output valid, output job_duration, input ready);
  modport sink   (input valid, input job_duration, output ready);
endinterface

interface pjs_result_if;
  logic                        valid;
  logic                        ready;
  logic [pjs_pkg::WIDX_W-1:0]  worker_index;
  logic [pjs_pkg::TIME_W-1:0]  start_time;
  logic                        time_saturated;

  modport source (output valid, output worker_index, output start_time,
                  output time_saturated, input ready);
  modport sink   (input valid, input worker_index, input start_time,
                  input time_saturated, output ready);
endinterface

`default_nettype wire

// File: hdl/parallel_job_scheduler_unit.sv
// ----------------------------------------------------------------------------
// parallel job scheduler unit
// greedy assignment of job durations to the earliest free worker
// ----------------------------------------------------------------------------
// usage:
//   cfg    : write channel for active_workers, always ready; write only while
//            the block is idle. zero counts as one, values above NUM_WORKERS
//            count as NUM_WORKERS
//   job    : one job_duration per transfer; ready only in the idle state
//   result : one transfer per job with worker_index, start_time and
//            time_saturated, held in an output register
// timing:
//   free times sit in a memory that one comparator scans, one worker per
//   cycle. after a job transfer come the scan of the active workers, a drain
//   step and the update step that loads the result; only then is a job taken
// reset:
//   after rst a clearing pass zeroes the memory, during which no job is
//   taken; active_workers returns to 16
// stall:
//   a waiting result does not block the next job transfer; that job's scan
//   runs and then holds in its update step until the output register is free
`default_nettype none
`include "parallel_job_scheduler_unit_macros.svh"

module parallel_job_scheduler_unit #(
  parameter int NUM_WORKERS = pjs_pkg::NUM_WORKERS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  pjs_cfg_if.sink           cfg,
  pjs_job_if.sink           job,
  pjs_result_if.source      result
);

  import pjs_pkg::*;

  localparam int IW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int CW = $clog2(NUM_WORKERS + 1);
  localparam int AW = (CW > CFG_W) ? CW : CFG_W;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_UPDATE = 5'b10000
  } state_t;

  state_t              state;
  logic [IW-1:0]       addr;
  logic [CFG_W-1:0]    active_workers;
  logic [DUR_W-1:0]    dur;

  logic [TIME_W-1:0]   free_mem [NUM_WORKERS];
  logic [TIME_W-1:0]   rd_data;
  logic [IW-1:0]       rd_idx;
  logic                rd_pending;

  logic [TIME_W-1:0]   best_time;
  logic [IW-1:0]       best_idx;

  logic                res_valid;
  logic [WIDX_W-1:0]   res_index;
  logic [TIME_W-1:0]   res_start;
  logic                res_sat;

  logic [AW-1:0]       act_ext;
  logic [AW-1:0]       act_clamp;
  logic [IW-1:0]       last_idx;
  logic                slot_free;
  logic [TIME_W:0]     sum;
  logic                sat;
  logic [TIME_W-1:0]   new_time;
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [TIME_W-1:0]   mem_wdata;

  // effective worker count, clamped to one .. NUM_WORKERS
  always_comb begin
    act_ext = AW'(active_workers);
    priority if (act_ext == '0) begin
      act_clamp = AW'(1);
    end else if (act_ext > AW'(NUM_WORKERS)) begin
      act_clamp = AW'(NUM_WORKERS);
    end else begin
      act_clamp = act_ext;
    end
  end

  assign last_idx  = IW'(act_clamp - AW'(1));
  assign slot_free = !res_valid || result.ready;

  // saturating add of the chosen start time and the duration
  assign sum      = {1'b0, best_time} + (TIME_W + 1)'(dur);
  assign sat      = (sum >= {1'b0, TIME_MAX});
  assign new_time = sat ? TIME_MAX : sum[TIME_W-1:0];

  assign mem_we    = (state == S_CLEAR) || ((state == S_UPDATE) && slot_free);
  assign mem_waddr = (state == S_CLEAR) ? addr : best_idx;
  assign mem_wdata = (state == S_CLEAR) ? '0 : new_time;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      free_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= free_mem[addr];
  end

  // running minimum, lowest index kept on a tie
  always_ff @(posedge clk) begin
    if (rd_pending) begin
      if ((rd_idx == '0) || (rd_data < best_time)) begin
        best_time <= rd_data;
        best_idx  <= rd_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      addr           <= '0;
      rd_pending     <= 1'b0;
      res_valid      <= 1'b0;
      active_workers <= ACTIVE_RESET;
    end else begin
      if (cfg.valid) begin
        active_workers <= cfg.active_workers;
      end

      if ((state == S_UPDATE) && slot_free) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end

      rd_pending <= (state == S_SCAN);
      rd_idx     <= addr;

      unique case (state)
        S_CLEAR: begin
          if (addr == IW'(NUM_WORKERS - 1)) begin
            addr  <= '0;
            state <= S_IDLE;
          end else begin
            addr <= addr + IW'(1);
          end
        end
        S_IDLE: begin
          if (job.valid) begin
            dur   <= job.job_duration;
            addr  <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (addr == last_idx) begin
            state <= S_DRAIN;
          end else begin
            addr <= addr + IW'(1);
          end
        end
        S_DRAIN: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (slot_free) begin
            res_index <= WIDX_W'(best_idx);
            res_start <= best_time;
            res_sat   <= sat;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
          addr  <= '0;
        end
      endcase
    end
  end

  assign cfg.ready = 1'b1;
  assign job.ready = (state == S_IDLE);

  assign result.valid          = res_valid;
  assign result.worker_index   = res_index;
  assign result.start_time     = res_start;
  assign result.time_saturated = res_sat;

  `PJS_ASSERT_NEXT(a_job_starts_scan, clk, rst, job.valid && job.ready,
    (state == S_SCAN) && (addr == '0), "job transfer did not start a scan at worker zero")

  `PJS_ASSERT_NEXT(a_update_loads_result, clk, rst, (state == S_UPDATE) && slot_free,
    res_valid && (state == S_IDLE), "update step did not load the output register")

  `PJS_ASSERT_NOW(a_best_in_range, clk, rst, state == S_UPDATE,
    best_idx <= last_idx, "chosen worker is outside the active range")

  `PJS_ASSERT_NEXT(a_result_held, clk, rst, res_valid && !result.ready,
    res_valid && $stable(res_start) && $stable(res_index), "stalled result was lost or changed")

endmodule

`default_nettype wire
